// ----- sv/sha512_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512 package
// round constants, initial hash values and round helper functions
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam int WordW   = 64;
  localparam int Rounds  = 80;
  localparam int BlkBytes = 128;

  typedef logic [63:0] word_t;

  localparam word_t RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam word_t InitHash [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  // control from sequencer to round unit
  typedef struct packed {
    logic       load;   // copy hash into working vars
    logic       round;  // run one round
    logic       fold;   // add working vars into hash
    logic       init;   // restore initial hash
    logic [6:0] rnd;
  } rnd_ctl_t;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

// ----- sv/sha512_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512 stream interfaces
// valid/ready channels for message bytes and digest words
// ----------------------------------------------------------------------------
interface sha512_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       has_byte;
  logic       is_last;
  modport source (output valid, byte_value, has_byte, is_last, input ready);
  modport sink (input valid, byte_value, has_byte, is_last, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- sv/sha512_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512 round unit
// one shared round datapath with working vars and hash words
// ----------------------------------------------------------------------------
module sha512_round (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha512_pkg::rnd_ctl_t ctl,
  input  sha512_pkg::word_t    w_in,
  output sha512_pkg::word_t    hash_o [8]
);

  sha512_pkg::word_t v_r [8];
  sha512_pkg::word_t h_r [8];
  sha512_pkg::word_t t1, t2, s1, s0, ch, mj;

  always_comb begin
    s1 = sha512_pkg::rotr(v_r[4], 14) ^ sha512_pkg::rotr(v_r[4], 18)
       ^ sha512_pkg::rotr(v_r[4], 41);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    s0 = sha512_pkg::rotr(v_r[0], 28) ^ sha512_pkg::rotr(v_r[0], 34)
       ^ sha512_pkg::rotr(v_r[0], 39);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1 = v_r[7] + s1 + ch + sha512_pkg::RoundK[ctl.rnd] + w_in;
    t2 = s0 + mj;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (ctl.round) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      for (int i = 0; i < 8; i++) h_r[i] <= sha512_pkg::InitHash[i];
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  assign hash_o = h_r;

endmodule

// ----- sv/sha512_stream_hasher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512 stream hasher
// byte-serial sha-512 with one shared round unit and a small sequencer
// ----------------------------------------------------------------------------
// a byte item is taken only in idle; the byte that fills a block starts a compression
// (load, 80 rounds through the single round unit, fold)
// a last item adds pad bytes plus one or two compressions,
// then 8 digest words; no item is taken until the digest is drained
// rst_n synchronous active low restores the initial hash and clears the count
module sha512_stream_hasher (
  input  logic clk,
  input  logic rst_n,
  sha512_in_if.sink    in_ch,
  sha512_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_PAD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]   st_r, st_nxt;
  logic [127:0] cnt_r;          // bit count
  logic [6:0]   fill_r;         // byte fill position
  logic         fin_r;          // padding phase of a finishing message
  logic         fin_pend_r;     // last item was the byte that filled a block
  logic         len_blk_r;      // current pad block carries the length
  logic [6:0]   rnd_r;
  logic [2:0]   oidx_r;
  sha512_pkg::word_t sch_r [16];
  sha512_pkg::word_t w_cur, w_new, hash_w [8];
  sha512_pkg::rnd_ctl_t ctl;
  logic [7:0]   pad_byte;
  logic         acc, wr_en;
  logic [7:0]   wr_data;
  logic [3:0]   ri;

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE);

  // pad byte: 0x80 right after the message, zeros, then the length
  // in the block that carries it (length msb first at byte 112)
  always_comb begin
    pad_byte = 8'h00;
    if (!fin_r) pad_byte = 8'h80;
    else if (len_blk_r && fill_r >= 7'd112) pad_byte = cnt_r[{~fill_r[3:0], 3'b111} -: 8];
  end

  // stream writes: message bytes in idle, pad bytes in pad state
  assign wr_en   = (acc && in_ch.has_byte) || (st_r == S_PAD);
  assign wr_data = (st_r == S_PAD) ? pad_byte : in_ch.byte_value;

  // schedule word for this round: loaded words in the first 16, else recurrence
  assign ri = rnd_r[3:0];
  assign w_new = sha512_pkg::sig1(sch_r[ri + 4'd14]) + sch_r[ri + 4'd9]
               + sha512_pkg::sig0(sch_r[ri + 4'd1]) + sch_r[ri];
  assign w_cur = (rnd_r < 7'd16) ? sch_r[ri] : w_new;

  // schedule window is filled by a byte shift as message and pad bytes arrive, then rewritten in later rounds
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sch_r[fill_r[6:3]] <= {sch_r[fill_r[6:3]][55:0], wr_data};
    end else if (st_r == S_RND && rnd_r >= 7'd16) begin
      sch_r[ri] <= w_new;
    end
  end

  always_comb begin
    ctl = '0;
    ctl.rnd   = rnd_r;
    ctl.load  = (st_r == S_LOAD);
    ctl.round = (st_r == S_RND);
    ctl.fold  = (st_r == S_FOLD);
    ctl.init  = (st_r == S_OUT) && out_ch.ready && (oidx_r == 3'd7);
  end

  sha512_round u_round (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .w_in(w_cur), .hash_o(hash_w)
  );

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (acc) begin
        if (in_ch.has_byte && fill_r == 7'h7f) st_nxt = S_LOAD;
        else if (in_ch.is_last) st_nxt = S_PAD;
      end
      S_LOAD: st_nxt = S_RND;
      S_RND:  if (rnd_r == 7'(sha512_pkg::Rounds - 1)) st_nxt = S_FOLD;
      S_FOLD: begin
        // after the length block the digest is ready, else more padding or idle
        if (fin_r) st_nxt = len_blk_r ? S_OUT : S_PAD;
        else st_nxt = fin_pend_r ? S_PAD : S_IDLE;
      end
      S_PAD:  if (fill_r == 7'h7f) st_nxt = S_LOAD;
      S_OUT:  if (out_ch.ready && oidx_r == 3'd7) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; fill_r <= '0; fin_r <= 1'b0;
      rnd_r <= '0; oidx_r <= '0; fin_pend_r <= 1'b0; len_blk_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (wr_en) fill_r <= fill_r + 7'd1;
      if (acc && in_ch.has_byte) cnt_r <= cnt_r + 128'd8;
      if (acc && in_ch.is_last && in_ch.has_byte && fill_r == 7'h7f) fin_pend_r <= 1'b1;
      if (st_r == S_PAD) begin
        fin_r <= 1'b1;
        // 0x80 below byte 112 leaves room for the length in this block
        if (!fin_r && fill_r < 7'd112) len_blk_r <= 1'b1;
      end
      if (st_r == S_LOAD) rnd_r <= '0;
      if (st_r == S_RND) rnd_r <= rnd_r + 7'd1;
      if (st_r == S_FOLD && !fin_r && fin_pend_r) fin_pend_r <= 1'b0;
      if (st_r == S_FOLD && fin_r && !len_blk_r) len_blk_r <= 1'b1;
      if (st_r == S_OUT && out_ch.ready) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          cnt_r <= '0; fin_r <= 1'b0; fill_r <= '0; len_blk_r <= 1'b0;
        end
      end
    end
  end

  assign out_ch.valid       = (st_r == S_OUT);
  assign out_ch.digest_word = hash_w[oidx_r];
  assign out_ch.word_index  = oidx_r;
  assign out_ch.last_word   = (oidx_r == 3'd7);

  // no item is taken during the rounds of a compression
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RND) |-> !in_ch.ready) else $error("ready during rounds");
  // rounds end with a fold
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RND && rnd_r == 7'd79) |=> (st_r == S_FOLD)) else $error("no fold");
  // digest words leave in order
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && oidx_r != 3'd7) |=> (oidx_r == $past(oidx_r) + 3'd1))
    else $error("word order");

endmodule

// ----- dv/sha512_digest_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512 digest checker
// watches both channels, hashes accepted bytes and compares digest words
// ----------------------------------------------------------------------------
module sha512_digest_checker (
  input  logic clk,
  input  logic rst_n,
  sha512_in_if  in_mon,
  sha512_out_if out_mon,
  output int    mismatch_count
);

  typedef struct packed {
    sha512_pkg::word_t digest_word;
    logic [2:0]        word_index;
    logic              last_word;
  } digest_item_t;

  sha512_pkg::word_t chain_hash [8];
  logic [7:0]    msg_block [128];
  logic [127:0]  msg_bits;
  digest_item_t  pending_words [$];

  function automatic sha512_pkg::word_t ror64(sha512_pkg::word_t x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_block();
    sha512_pkg::word_t w [80];
    sha512_pkg::word_t v [8];
    sha512_pkg::word_t t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 8; j++) w[i] = {w[i][55:0], msg_block[i*8+j]};
    for (int t = 16; t < 80; t++) begin
      s0 = ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7);
      s1 = ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
    for (int t = 0; t < 80; t++) begin
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha512_pkg::RoundK[t] + w[t];
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_hash[i] = chain_hash[i] + v[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain_hash[i] = sha512_pkg::InitHash[i];
    msg_bits = '0;
  endtask

  // one accepted input item: absorb byte, and on end of message pad and emit
  task automatic absorb_item(logic [7:0] b, logic has_b, logic last_b);
    int fill;
    digest_item_t d;
    fill = msg_bits[9:3];
    if (has_b) begin
      msg_block[fill] = b;
      msg_bits = msg_bits + 128'd8;
      if (fill == 127) compress_block();
    end
    if (!last_b) return;
    fill = msg_bits[9:3];
    msg_block[fill] = 8'h80;
    for (int i = fill + 1; i < 128; i++) msg_block[i] = 8'h00;
    if (fill >= 112) begin
      compress_block();
      for (int i = 0; i < 112; i++) msg_block[i] = 8'h00;
    end
    for (int i = 0; i < 16; i++) msg_block[112+i] = msg_bits[127-8*i -: 8];
    compress_block();
    for (int k = 0; k < 8; k++) begin
      d.digest_word = chain_hash[k];
      d.word_index  = 3'(k);
      d.last_word   = (k == 7);
      pending_words.push_back(d);
    end
    restart_message();
  endtask

  initial begin
    mismatch_count = 0;
    restart_message();
  end

  always @(posedge clk) begin
    digest_item_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        absorb_item(in_mon.byte_value, in_mon.has_byte, in_mon.is_last);
      if (out_mon.valid && out_mon.ready) begin
        if (pending_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected digest word %h idx %0d", out_mon.digest_word,
                     out_mon.word_index);
        end else begin
          want = pending_words.pop_front();
          if (want != {out_mon.digest_word, out_mon.word_index, out_mon.last_word})
          begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                       want.digest_word, want.word_index, want.last_word,
                       out_mon.digest_word, out_mon.word_index, out_mon.last_word);
          end
        end
      end
    end
  end

  function automatic int words_outstanding();
    return pending_words.size();
  endfunction

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512 stream hasher testbench
// drives byte messages with random gaps and stalls, verdict from the checker
// ----------------------------------------------------------------------------
module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatch_count;
  int   idle_cycles;
  bit   source_done;
  bit   hold_sink;      // forces a long receiver stall
  bit   calm_phase;     // no idling on either side

  sha512_in_if  in_ch ();
  sha512_out_if out_ch ();

  sha512_stream_hasher i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sha512_digest_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count)
  );

  always #5 clk = ~clk;

  // send one item, with a random gap first unless in the calm phase
  task automatic send_item(logic [7:0] b, logic has_b, logic last_b);
    @(negedge clk);
    while (!calm_phase && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.byte_value <= b;
    in_ch.has_byte   <= has_b;
    in_ch.is_last    <= last_b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // drop valid once a run of items is over
  task automatic stop_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // a whole message of random bytes with sprinkled empty items
  task automatic send_message(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1));
    end
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 20) return $urandom_range(129, 140);
    return $urandom_range(1, 24);
  endfunction

  // receiver: random ready, long hold when asked
  always @(negedge clk) begin
    if (!rst_n || hold_sink) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 38);
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_sink)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int sent;
    in_ch.valid = 1'b0;
    in_ch.byte_value = '0;
    in_ch.has_byte = 1'b0;
    in_ch.is_last = 1'b0;
    out_ch.ready = 1'b0;
    idle_cycles = 0;
    hold_sink = 1'b0;
    calm_phase = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty message, empty items, extreme bytes, one-byte messages
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'haa, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // padding boundaries: 111, 112 and 127/128 byte messages
    send_message(111);
    send_message(112);
    // long stretch with no idling on either side
    calm_phase = 1'b1;
    send_message(127);
    send_message(128);
    calm_phase = 1'b0;

    // receiver held off while a message completes and the next one queues
    fork
      begin
        hold_sink = 1'b1;
        repeat (600) @(negedge clk);
        hold_sink = 1'b0;
      end
      begin
        send_message(3);
        send_message(2);
        stop_input();
      end
    join

    sent = 0;
    while (sent < 20) begin
      int len;
      len = pick_length();
      send_message(len);
      sent += (len == 0) ? 1 : len;
    end
    stop_input();

    while (i_checker.words_outstanding() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
